// ----- design/ptw_pkg.sv -----
// Shared constants, types and helper functions for the page table walker.
package ptw_pkg;

  localparam int TABLE_WORDS = 4096;
  localparam int TW_BITS     = $clog2(TABLE_WORDS);

  localparam int IDX_W  = 12;
  localparam int WORD_W = 64;
  localparam int VA_W   = 48;
  localparam int PA_W   = 52;
  localparam int KIND_W = 2;

  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_TRANSLATE = 1'b1;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_4K = 2'd0;
  localparam logic [KIND_W-1:0] KIND_2M = 2'd1;
  localparam logic [KIND_W-1:0] KIND_1G = 2'd2;

  localparam int PRESENT_POS = 0;
  localparam int SIZE_POS    = 7;

  typedef struct packed {
    logic clear;
    logic write;
    logic start;
    logic step;
    logic load_out;
  } ptw_cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic       present;
    logic       page_size;
    logic [1:0] level;
  } ptw_status_t;

  function automatic logic [TW_BITS-1:0] store_index(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] wide;
    wide = WORD_W'(idx);
    return wide[TW_BITS-1:0];
  endfunction

  function automatic logic [TW_BITS-1:0] entry_word(input logic [PA_W-1:0] base,
                                                    input logic [8:0] slot);
    logic [PA_W-4:0] word;
    word = {base[PA_W-1:12], slot};
    return word[TW_BITS-1:0];
  endfunction

endpackage

// ----- design/ptw_if.sv -----
// Handshake channel interfaces for requests, responses and root register writes.
interface ptw_req_if import ptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [IDX_W-1:0]  word_index;
  logic [WORD_W-1:0] word_value;
  logic [VA_W-1:0]   virtual_address;

  modport source (output valid, action, word_index, word_value, virtual_address,
                  input ready);
  modport sink (input valid, action, word_index, word_value, virtual_address,
                output ready);
endinterface

interface ptw_rsp_if import ptw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PA_W-1:0]   physical_address;
  logic              fault;
  logic [KIND_W-1:0] page_kind;

  modport source (output valid, physical_address, fault, page_kind, input ready);
  modport sink (input valid, physical_address, fault, page_kind, output ready);
endinterface

interface ptw_cfg_if import ptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PA_W-1:0] root_table_base;

  modport source (output valid, root_table_base, input ready);
  modport sink (input valid, root_table_base, output ready);
endinterface

// ----- design/ptw_ctrl.sv -----
// Walk controller: clearing pass, request acceptance, level sequencing, response beat.
module ptw_ctrl import ptw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_action,
  output logic        req_ready,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  input  ptw_status_t status,
  output ptw_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_WALK   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid;
  logic   accept;
  logic   walk_done;
  logic   slot_free;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign slot_free = !out_valid || rsp_ready;
  assign rsp_valid = out_valid;

  assign walk_done = !status.present || (status.level == LVL_PT) ||
                     (status.page_size && ((status.level == LVL_PDPT) ||
                                           (status.level == LVL_PD)));

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.clear    = (state == ST_CLEAR);
    cmd.write    = accept && (req_action == ACT_WRITE);
    cmd.start    = accept && (req_action == ACT_TRANSLATE);
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.start) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (!walk_done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (rsp_ready) out_valid <= 1'b0;
    end
  end

  a_start_walks: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_WALK)
    else $error("translate beat did not start a walk");

  a_pt_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) && (status.level == LVL_PT) |=> state != ST_WALK)
    else $error("walk continued past the last level");

  a_level_advances: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) && $past(state == ST_WALK) |->
      status.level == 2'($past(status.level) + 2'd1))
    else $error("walk level did not advance");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded response not presented");

endmodule

// ----- design/ptw_datapath.sv -----
// Walk datapath: table store, root register, entry decode and response register.
module ptw_datapath import ptw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ptw_cmd_t          cmd,
  output ptw_status_t       status,
  input  logic [IDX_W-1:0]  word_index,
  input  logic [WORD_W-1:0] word_value,
  input  logic [VA_W-1:0]   virtual_address,
  input  logic              root_we,
  input  logic [PA_W-1:0]   root_wdata,
  output logic [PA_W-1:0]   physical_address,
  output logic              fault,
  output logic [KIND_W-1:0] page_kind
);

  logic [WORD_W-1:0] mem [TABLE_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic [TW_BITS-1:0] rd_addr;
  logic [TW_BITS-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [TW_BITS-1:0] clr_cnt;
  logic [PA_W-1:0]    root;
  logic [VA_W-1:0]    va;
  logic [1:0]         level;
  logic [8:0]         slot;
  logic [PA_W-1:0]    pa_next;
  logic [KIND_W-1:0]  kind_next;

  always_comb begin
    case (level)
      LVL_PML4: slot = va[38:30];
      LVL_PDPT: slot = va[29:21];
      default:  slot = va[20:12];
    endcase
    if (cmd.start) rd_addr = entry_word(root, virtual_address[47:39]);
    else rd_addr = entry_word(rd_data[PA_W-1:0], slot);
    wr_addr = cmd.clear ? clr_cnt : store_index(word_index);
    wr_data = cmd.clear ? '0 : word_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear || cmd.write) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.step) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      root    <= '0;
    end else begin
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (root_we) root <= root_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      va    <= virtual_address;
      level <= LVL_PML4;
    end else if (cmd.step) begin
      level <= level + 2'd1;
    end
  end

  assign status.clear_last = (clr_cnt == '1);
  assign status.present    = rd_data[PRESENT_POS];
  assign status.page_size  = rd_data[SIZE_POS];
  assign status.level      = level;

  always_comb begin
    pa_next   = '0;
    kind_next = KIND_4K;
    if (rd_data[PRESENT_POS]) begin
      case (level)
        LVL_PDPT: begin
          pa_next   = {rd_data[51:30], va[29:0]};
          kind_next = KIND_1G;
        end
        LVL_PD: begin
          pa_next   = {rd_data[51:21], va[20:0]};
          kind_next = KIND_2M;
        end
        default: begin
          pa_next   = {rd_data[51:12], va[11:0]};
          kind_next = KIND_4K;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      physical_address <= pa_next;
      fault            <= !rd_data[PRESENT_POS];
      page_kind        <= kind_next;
    end
  end

endmodule

// ----- design/four_level_page_table_walker_unit.sv -----
// Four-level page table walker: top level joining controller and datapath.
// After reset the 4096-word table store is zeroed by a clearing pass, during which no
// request beat is taken; root register writes are taken at any time. A translation reads
// one store word per level from a memory with one read port, one write port and a registered
// read, and its result is loaded once the last read is done and the response register is free
// (1 GiB pages after two reads, 2 MiB after three, 4 KiB after four, faults after the read that
// finds the entry not present); the next request is taken the cycle after. No new request is
// taken while a walk is in progress.
// The response register lets the next request be taken while a result waits to be read.
module four_level_page_table_walker_unit import ptw_pkg::*; (
  input logic     clk,
  input logic     rst,
  ptw_req_if.sink   req,
  ptw_rsp_if.source rsp,
  ptw_cfg_if.sink   cfg
);

  ptw_cmd_t    cmd;
  ptw_status_t status;

  assign cfg.ready = 1'b1;

  ptw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .status     (status),
    .cmd        (cmd)
  );

  ptw_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .word_index       (req.word_index),
    .word_value       (req.word_value),
    .virtual_address  (req.virtual_address),
    .root_we          (cfg.valid),
    .root_wdata       (cfg.root_table_base),
    .physical_address (rsp.physical_address),
    .fault            (rsp.fault),
    .page_kind        (rsp.page_kind)
  );

endmodule

// ----- tb/sv/tb_four_level_page_table_walker_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the four-level page table walker.
module tb_four_level_page_table_walker_unit;
  import ptw_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    logic              action;
    logic [IDX_W-1:0]  word_index;
    logic [WORD_W-1:0] word_value;
    logic [VA_W-1:0]   virtual_address;
  } table_req_t;

  typedef struct {
    logic [PA_W-1:0]   phys;
    logic              fault;
    logic [KIND_W-1:0] kind;
  } walk_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ptw_req_if req_ch ();
  ptw_rsp_if rsp_ch ();
  ptw_cfg_if cfg_ch ();

  four_level_page_table_walker_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  table_req_t   request_q[$];
  walk_result_t expected_walks_q[$];

  logic [WORD_W-1:0] table_copy [TABLE_WORDS];
  logic [PA_W-1:0]   root_copy;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_off_request = 0;
  int  hold_off_left = 0;
  int  items_queued = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  writes_seen = 0;
  int  root_writes = 0;
  int  walks_4k = 0;
  int  walks_2m = 0;
  int  walks_1g = 0;
  int  walks_faulted = 0;
  bit  req_accepted = 1'b0;

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VA_W-1:0] rand_va();
    logic [WORD_W-1:0] bits;
    bits = {$urandom, $urandom};
    return bits[VA_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] fetch_entry(input logic [WORD_W-1:0] table_ptr,
                                                    input logic [8:0] slot);
    logic [48:0] word_addr;
    word_addr = {table_ptr[51:12], slot};
    return table_copy[word_addr % TABLE_WORDS];
  endfunction

  function automatic walk_result_t walk_tables(input logic [VA_W-1:0] va);
    walk_result_t res;
    logic [WORD_W-1:0] entry;
    res.phys  = '0;
    res.fault = 1'b0;
    res.kind  = KIND_4K;
    entry = {{(WORD_W-PA_W){1'b0}}, root_copy};
    for (int lvl = 0; lvl < 4; lvl++) begin
      entry = fetch_entry(entry, va[47 - 9*lvl -: 9]);
      if (!entry[PRESENT_POS]) begin
        res.fault = 1'b1;
        return res;
      end
      if (lvl == LVL_PDPT && entry[SIZE_POS]) begin
        res.phys = {entry[51:30], va[29:0]};
        res.kind = KIND_1G;
        return res;
      end
      if (lvl == LVL_PD && entry[SIZE_POS]) begin
        res.phys = {entry[51:21], va[20:0]};
        res.kind = KIND_2M;
        return res;
      end
    end
    res.phys = {entry[51:12], va[11:0]};
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Track accepted beats, keep the table copy current and check results.
  always @(posedge clk) begin : beat_monitor
    walk_result_t want;
    walk_result_t got;
    if (rst) begin
      req_accepted = 1'b0;
    end else begin
      req_accepted = req_ch.valid && req_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        root_copy = cfg_ch.root_table_base;
        root_writes++;
      end
      if (req_accepted) begin
        if (req_ch.action == ACT_WRITE) begin
          table_copy[req_ch.word_index % TABLE_WORDS] = req_ch.word_value;
          writes_seen++;
        end else begin
          want = walk_tables(req_ch.virtual_address);
          expected_walks_q.push_back(want);
          if (want.fault) walks_faulted++;
          else if (want.kind == KIND_1G) walks_1g++;
          else if (want.kind == KIND_2M) walks_2m++;
          else walks_4k++;
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.phys  = rsp_ch.physical_address;
        got.fault = rsp_ch.fault;
        got.kind  = rsp_ch.page_kind;
        if (expected_walks_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: pa %h fault %0d kind %0d",
                     got.phys, got.fault, got.kind);
        end else begin
          want = expected_walks_q.pop_front();
          if (got.phys !== want.phys || got.fault !== want.fault || got.kind !== want.kind)
          begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: pa exp %h got %h, fault exp %0d got %0d, kind exp %0d got %0d",
                       want.phys, got.phys, want.fault, got.fault, want.kind, got.kind);
          end
        end
      end
    end
  end

  always @(negedge clk) begin : request_driver
    table_req_t beat;
    if (rst) begin
      req_ch.valid           <= 1'b0;
      req_ch.action          <= ACT_WRITE;
      req_ch.word_index      <= '0;
      req_ch.word_value      <= '0;
      req_ch.virtual_address <= '0;
    end else if (!req_ch.valid || req_accepted) begin
      if (request_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        beat = request_q.pop_front();
        req_ch.valid           <= 1'b1;
        req_ch.action          <= beat.action;
        req_ch.word_index      <= beat.word_index;
        req_ch.word_value      <= beat.word_value;
        req_ch.virtual_address <= beat.virtual_address;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : result_sink
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (hold_off_request > 0) begin
        hold_off_left = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    table_req_t beat;
    beat.action          = ACT_WRITE;
    beat.word_index      = idx;
    beat.word_value      = value;
    beat.virtual_address = rand_va();
    request_q.push_back(beat);
    items_queued++;
  endtask

  task automatic queue_xlate(input logic [VA_W-1:0] va);
    table_req_t beat;
    beat.action          = ACT_TRANSLATE;
    beat.word_index      = IDX_W'($urandom_range(0, TABLE_WORDS - 1));
    beat.word_value      = rand_word();
    beat.virtual_address = va;
    request_q.push_back(beat);
    items_queued++;
  endtask

  // Build one walk's entries under the given root page; translate it and up to two nearby addresses.
  task automatic queue_walk(input logic [2:0] root_page);
    logic [VA_W-1:0]   va;
    logic [VA_W-1:0]   near_va;
    logic [WORD_W-1:0] entry;
    logic [2:0]        page;
    logic [2:0]        next_page;
    logic [8:0]        slot;
    int                depth;
    int                fault_level;
    int                lookups;
    va = rand_va();
    depth = 2 + $urandom_range(0, 2);
    fault_level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, depth - 1) : depth;
    page = root_page;
    for (int lvl = 0; lvl < depth && lvl <= fault_level; lvl++) begin
      slot = va[47 - 9*lvl -: 9];
      next_page = 3'($urandom_range(0, 7));
      entry = rand_word();
      entry[14:12] = next_page;
      entry[PRESENT_POS] = (lvl != fault_level);
      if (lvl == LVL_PDPT) entry[SIZE_POS] = (depth == 2);
      else if (lvl == LVL_PD) entry[SIZE_POS] = (depth == 3);
      if ($urandom_range(0, 15) != 0) queue_write({page, slot}, entry);
      page = next_page;
    end
    queue_xlate(va);
    lookups = $urandom_range(0, 2);
    for (int n = 0; n < lookups; n++) begin
      near_va = va;
      near_va[11:0] = 12'($urandom);
      if ($urandom_range(0, 2) == 0) near_va[29:12] = 18'($urandom);
      queue_xlate(near_va);
    end
  endtask

  task automatic write_root(input logic [PA_W-1:0] base);
    @(negedge clk);
    cfg_ch.root_table_base <= base;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (request_q.size() != 0 || req_ch.valid || expected_walks_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [PA_W-1:0] root, input int send_pct, input int recv_pct,
                           input int item_goal, input int hold_cycles);
    int goal;
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_root(root);
    hold_off_request = hold_cycles;
    goal = items_queued + item_goal;
    while (items_queued < goal) begin
      case ($urandom_range(0, 9))
        0: queue_write(IDX_W'($urandom_range(0, TABLE_WORDS - 1)), rand_word());
        1: queue_xlate(rand_va());
        default: queue_walk(root[14:12]);
      endcase
    end
  endtask

  initial begin
    logic [WORD_W-1:0] scratch;
    cfg_ch.valid           = 1'b0;
    cfg_ch.root_table_base = '0;
    root_copy              = '0;
    foreach (table_copy[i]) table_copy[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed walks under root page 0, mostly through the top slot of each level, some through slot 0.
    send_idle_pct = 12;
    recv_idle_pct = 81;
    write_root('0);
    queue_xlate(48'h0);
    queue_xlate(48'hFFFF_FFFF_FFFF);
    queue_write(12'd511, 64'hFFF0_0000_0000_9081);
    queue_write(12'd1023, 64'h8000_0000_0000_2001);
    queue_write(12'd1535, 64'h0000_0000_0000_7001);
    queue_write(12'd4095, 64'hFFFF_FFFF_FFFF_F081);
    queue_xlate(48'hFFFF_FFFF_FFFF);
    queue_write(12'd1023, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_xlate(48'hFFFF_FFFF_FFFF);
    queue_xlate(48'hFF80_0000_0000);
    queue_write(12'd1023, 64'h0000_0000_0000_2001);
    queue_write(12'd1535, 64'h7FFF_FFFF_FFE0_0081);
    queue_xlate(48'hFFFF_FFFF_FFFF);
    queue_write(12'd1535, 64'hFFFF_FFFF_FFFF_FFFE);
    queue_xlate(48'hFFFF_FFFF_FFFF);
    queue_write(12'd1535, 64'h0000_0000_0000_7001);
    queue_write(12'd4095, 64'h0);
    queue_xlate(48'hFFFF_FFFF_FFFF);
    queue_write(12'd0, 64'h0000_0000_0000_0001);
    queue_xlate(48'h0);
    queue_xlate(48'h0000_0000_0ABC);

    run_phase({PA_W{1'b1}}, 12, 81, 380, 0);
    scratch = rand_word();
    run_phase(scratch[PA_W-1:0], 81, 12, 380, 0);
    scratch = rand_word();
    run_phase(scratch[PA_W-1:0], 0, 0, 380, HOLD_OFF_CYCLES);
    run_phase('0, 0, 0, 390, 0);
    wait_drained();

    $display("summary: %0d table writes, %0d root writes, %0d translations checked",
             writes_seen, root_writes, walks_4k + walks_2m + walks_1g + walks_faulted);
    $display("summary: 4 KiB %0d, 2 MiB %0d, 1 GiB %0d, faults %0d, errors %0d",
             walks_4k, walks_2m, walks_1g, walks_faulted, error_count);
    if (error_count == 0 && expected_walks_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ----- four_level_page_table_walker_unit.f -----
design/ptw_pkg.sv
design/ptw_if.sv
design/ptw_ctrl.sv
design/ptw_datapath.sv
design/four_level_page_table_walker_unit.sv
tb/sv/tb_four_level_page_table_walker_unit.sv
